>>> rtl/wrs_pkg.sv
// shared types, codes and constants of the windowed regression scaling block
`timescale 1ns / 1ps

package wrs_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam logic [15:0] WLEN_RESET      = 16'd1000;

  // long division widths: magnitude of a 128-bit product difference, scaled by 2^16
  localparam int unsigned DEN_W   = 128;
  localparam int unsigned DVD_W   = DEN_W + 16;
  localparam int unsigned OUT_W   = 136;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WMUL,
    S_WDRAIN,
    S_WCOMMIT,
    S_NMUL,
    S_NDRAIN,
    S_NDIFF,
    S_DMUL,
    S_DDRAIN,
    S_DDIFF,
    S_DIVGO,
    S_DIVWAIT,
    S_LOAD
  } wrs_state_e;

  typedef enum logic [2:0] {
    PAIR_N_SXY,
    PAIR_SX_SY,
    PAIR_N_SXX,
    PAIR_SX_SX,
    PAIR_WA_WA,
    PAIR_WA_WB
  } mul_pair_e;

  typedef enum logic [1:0] {
    DIV_FREE,
    DIV_ORIGIN,
    DIV_TOTAL
  } div_sel_e;

  typedef struct packed {
    logic      in_ready;
    logic      item;
    logic      mul_go;
    mul_pair_e mul_pair;
    logic [1:0] mul_part;
    logic      mul_dst;
    logic      win_commit;
    logic      num_latch;
    logic      den_latch;
    logic      div_start;
    logic      div_store;
    div_sel_e  div_sel;
    logic      out_load;
  } wrs_cmd_t;

  typedef struct packed {
    logic win_hit;
    logic div_done;
    logic out_busy;
  } wrs_st_t;

endpackage

>>> rtl/windowed_regression_scaling_top.sv
// top level of the windowed regression scaling block
`timescale 1ns / 1ps

// Windowed regression scaling: takes paired Q12.4 samples of two profiles, keeps
// each profile's total and, until a position lacks either profile, sums samples over
// windows of window_length positions (0 means 65536). Windows whose two sums are
// both positive feed saturating n, Sx, Sy, Sxx and Sxy accumulators. The request
// marked tlast produces one result: the two-parameter slope, the slope through
// the origin and the ratio of totals as Q16.16, the window count and four flags;
// then all run state clears. An item that closes a counted window computes two
// products on the shared 32x32 multiplier, then commits. A last item adds 16
// partial products on the shared multiplier with drain and difference steps,
// then three 144-step bit-serial divisions, then a load of the result.
// The result sits in an output register; the block then takes new requests while
// it waits to be taken, and only a following last request waits for that register
// to free up. No clearing pass is needed after reset.
module windowed_regression_scaling_top import wrs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration: window_length
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [15:0]  cfg_data_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // sample_a[15:0], sample_b[31:16], has_a[32], has_b[33]
  input  logic         s_axis_tlast,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // slope_free[31:0], slope_origin[63:32],
                                       // total_ratio[95:64], windows_used[127:96],
                                       // free_den_zero[128], origin_den_zero[129],
                                       // total_den_zero[130], overflowed[131]
);

  wrs_cmd_t cmd;
  wrs_st_t  st;

  // register writes must happen only while idle (the block does not enforce this), so always ready
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = cmd.in_ready;

  wrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  wrs_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .sample_a_i  (s_axis_tdata[15:0]),
    .sample_b_i  (s_axis_tdata[31:16]),
    .has_a_i     (s_axis_tdata[32]),
    .has_b_i     (s_axis_tdata[33]),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_data_o  (m_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule

>>> rtl/wrs_div.sv
// bit-serial restoring divider, one quotient bit per cycle, 32-bit quotient with overflow
`timescale 1ns / 1ps

module wrs_div import wrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DEN_W-1:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic             ovf_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [31:0]      quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_d   = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    quo_d   = {quo_q[30:0], ge};
    ovf_d   = ovf_q | quo_q[31];
    dvd_d   = {dvd_q[DVD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      quo_q <= quo_d;
      ovf_q <= ovf_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign ovf_o  = ovf_q;

endmodule

>>> rtl/wrs_dp.sv
// datapath: window sums, saturating accumulators, shared multiplier, ratios and result register
`timescale 1ns / 1ps

module wrs_dp import wrs_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_data_i,
  input  logic [15:0]      sample_a_i,
  input  logic [15:0]      sample_b_i,
  input  logic             has_a_i,
  input  logic             has_b_i,
  input  wrs_cmd_t         cmd_i,
  output wrs_st_t          st_o,
  output logic [OUT_W-1:0] out_data_o,
  output logic             out_valid_o,
  input  logic             out_ready_i
);

  localparam logic [31:0] SMASK = 32'((64'd1 << SAMPLE_BITS) - 64'd1);

  function automatic logic [64:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {1'b1, {64{1'b1}}} : s;
  endfunction

  function automatic logic [32:0] sadd32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? {1'b1, {32{1'b1}}} : s;
  endfunction

  // configuration and window state
  logic [15:0]  wlen_q;
  logic [15:0]  pos_q, pos_d;
  logic [31:0]  wsa_q, wsa_d, wsb_q, wsb_d;
  logic         pend_q, pend_d;
  logic [63:0]  tota_q, tota_d, totb_q, totb_d;
  logic [31:0]  cnt_q, cnt_d;
  logic [63:0]  sx_q, sx_d, sy_q, sy_d, sxx_q, sxx_d, sxy_q, sxy_d;
  logic         sat_q, sat_d;
  logic [31:0]  xh_q, xh_d, yh_q, yh_d;

  // multiplier and product accumulators
  logic [63:0]  mul_q;
  logic [1:0]   msh_q;
  logic         mdst_q, mv_q;
  logic [127:0] accp_q, accq_q, addend;
  logic [63:0]  opx, opy;
  logic [31:0]  xl, yl;

  // difference magnitudes
  logic [127:0] num_q, den_q, dmag;
  logic         nneg_q, dneg_q, p_ge;

  // divider
  logic [DVD_W-1:0] dvd;
  logic [DEN_W-1:0] dsr;
  logic             div_done, div_ovf;
  logic [31:0]      div_quo;

  // ratio results
  logic [31:0]  free_q, orig_q, tot_q;
  logic         fz_q, oz_q, tz_q;
  logic [31:0]  lim, mag, sres;
  logic         neg;

  logic [OUT_W-1:0] odata_q;
  logic             ov_q;

  // item logic
  logic [31:0] a32, b32;
  logic [32:0] wsa_sum, wsb_sum;
  logic        close, pair, win_run, hit;
  logic [64:0] r64a, r64b, r64c, r64d;
  logic [32:0] r32;

  always_comb begin
    a32     = {16'b0, sample_a_i} & SMASK;
    b32     = {16'b0, sample_b_i} & SMASK;
    wsa_sum = sadd32(wsa_q, a32);
    wsb_sum = sadd32(wsb_q, b32);
    close   = ({1'b0, pos_q} + 17'd1) >= {(wlen_q == 16'd0), wlen_q};
    pair    = has_a_i & has_b_i;
    win_run = pair & ~pend_q;
    hit     = win_run & close & (wsa_sum[31:0] != '0) & (wsb_sum[31:0] != '0);
  end

  always_comb begin
    pos_d  = pos_q;
    wsa_d  = wsa_q;
    wsb_d  = wsb_q;
    pend_d = pend_q;
    tota_d = tota_q;
    totb_d = totb_q;
    cnt_d  = cnt_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    sxx_d  = sxx_q;
    sxy_d  = sxy_q;
    sat_d  = sat_q;
    xh_d   = xh_q;
    yh_d   = yh_q;
    r64a   = sadd64(tota_q, {32'b0, a32});
    r64b   = sadd64(totb_q, {32'b0, b32});
    r64c   = sadd64(sx_q, {32'b0, wsa_sum[31:0]});
    r64d   = sadd64(sy_q, {32'b0, wsb_sum[31:0]});
    r32    = sadd32(cnt_q, 32'd1);
    if (cmd_i.item) begin
      if (has_a_i) begin
        tota_d = r64a[63:0];
        sat_d  = sat_d | r64a[64];
      end
      if (has_b_i) begin
        totb_d = r64b[63:0];
        sat_d  = sat_d | r64b[64];
      end
      if (!pair) begin
        pend_d = 1'b1;
        pos_d  = '0;
        wsa_d  = '0;
        wsb_d  = '0;
      end else if (!pend_q) begin
        sat_d = sat_d | wsa_sum[32] | wsb_sum[32];
        if (close) begin
          pos_d = '0;
          wsa_d = '0;
          wsb_d = '0;
          if (hit) begin
            cnt_d = r32[31:0];
            sx_d  = r64c[63:0];
            sy_d  = r64d[63:0];
            sat_d = sat_d | r32[32] | r64c[64] | r64d[64];
            xh_d  = wsa_sum[31:0];
            yh_d  = wsb_sum[31:0];
          end
        end else begin
          pos_d = pos_q + 16'd1;
          wsa_d = wsa_sum[31:0];
          wsb_d = wsb_sum[31:0];
        end
      end
    end
    if (cmd_i.win_commit) begin
      r64a  = sadd64(sxx_q, accp_q[63:0]);
      r64b  = sadd64(sxy_q, accq_q[63:0]);
      sxx_d = r64a[63:0];
      sxy_d = r64b[63:0];
      sat_d = sat_d | r64a[64] | r64b[64];
    end
    if (cmd_i.out_load) begin
      pos_d  = '0;
      wsa_d  = '0;
      wsb_d  = '0;
      pend_d = 1'b0;
      tota_d = '0;
      totb_d = '0;
      cnt_d  = '0;
      sx_d   = '0;
      sy_d   = '0;
      sxx_d  = '0;
      sxy_d  = '0;
      sat_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
      pos_q  <= '0;
      wsa_q  <= '0;
      wsb_q  <= '0;
      pend_q <= 1'b0;
      tota_q <= '0;
      totb_q <= '0;
      cnt_q  <= '0;
      sx_q   <= '0;
      sy_q   <= '0;
      sxx_q  <= '0;
      sxy_q  <= '0;
      sat_q  <= 1'b0;
      mv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_data_i;
      end
      pos_q  <= pos_d;
      wsa_q  <= wsa_d;
      wsb_q  <= wsb_d;
      pend_q <= pend_d;
      tota_q <= tota_d;
      totb_q <= totb_d;
      cnt_q  <= cnt_d;
      sx_q   <= sx_d;
      sy_q   <= sy_d;
      sxx_q  <= sxx_d;
      sxy_q  <= sxy_d;
      sat_q  <= sat_d;
      mv_q   <= cmd_i.mul_go;
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // operand selection for the shared 32x32 multiplier
  always_comb begin
    unique case (cmd_i.mul_pair)
      PAIR_N_SXY: begin opx = {32'b0, cnt_q}; opy = sxy_q; end
      PAIR_SX_SY: begin opx = sx_q;           opy = sy_q;  end
      PAIR_N_SXX: begin opx = {32'b0, cnt_q}; opy = sxx_q; end
      PAIR_SX_SX: begin opx = sx_q;           opy = sx_q;  end
      PAIR_WA_WA: begin opx = {32'b0, xh_q};  opy = {32'b0, xh_q}; end
      PAIR_WA_WB: begin opx = {32'b0, xh_q};  opy = {32'b0, yh_q}; end
      default:    begin opx = '0;             opy = '0;    end
    endcase
    xl     = cmd_i.mul_part[1] ? opx[63:32] : opx[31:0];
    yl     = cmd_i.mul_part[0] ? opy[63:32] : opy[31:0];
    addend = {64'b0, mul_q} << {msh_q, 5'b0};
    p_ge   = accp_q >= accq_q;
    dmag   = p_ge ? (accp_q - accq_q) : (accq_q - accp_q);
  end

  always_ff @(posedge clk_i) begin
    xh_q <= xh_d;
    yh_q <= yh_d;
    if (cmd_i.mul_go) begin
      mul_q  <= xl * yl;
      msh_q  <= 2'(cmd_i.mul_part[1]) + 2'(cmd_i.mul_part[0]);
      mdst_q <= cmd_i.mul_dst;
    end
    if (cmd_i.item || cmd_i.win_commit || cmd_i.num_latch) begin
      accp_q <= '0;
      accq_q <= '0;
    end else if (mv_q) begin
      if (mdst_q) begin
        accq_q <= accq_q + addend;
      end else begin
        accp_q <= accp_q + addend;
      end
    end
    if (cmd_i.num_latch) begin
      num_q  <= dmag;
      nneg_q <= ~p_ge;
    end
    if (cmd_i.den_latch) begin
      den_q  <= dmag;
      dneg_q <= ~p_ge;
    end
  end

  // divider operands
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_FREE:   begin dvd = {num_q, 16'b0};               dsr = den_q; end
      DIV_ORIGIN: begin dvd = {64'b0, sxy_q, 16'b0};        dsr = {64'b0, sxx_q}; end
      DIV_TOTAL:  begin dvd = {64'b0, totb_q, 16'b0};       dsr = {64'b0, tota_q}; end
      default:    begin dvd = '0;                           dsr = '0; end
    endcase
  end

  wrs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dsr),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .ovf_o      (div_ovf)
  );

  // clamp and sign of the quotient
  always_comb begin
    neg  = (cmd_i.div_sel == DIV_FREE) & (nneg_q ^ dneg_q);
    if (cmd_i.div_sel == DIV_FREE) begin
      lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      lim = 32'hFFFF_FFFF;
    end
    mag  = (div_ovf || (div_quo > lim)) ? lim : div_quo;
    sres = neg ? (32'd0 - mag) : mag;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        DIV_FREE: begin
          fz_q   <= (dsr == '0);
          free_q <= (dsr == '0) ? 32'd0 : sres;
        end
        DIV_ORIGIN: begin
          oz_q   <= (dsr == '0);
          orig_q <= (dsr == '0) ? 32'd0 : sres;
        end
        DIV_TOTAL: begin
          tz_q  <= (dsr == '0);
          tot_q <= (dsr == '0) ? 32'd0 : sres;
        end
        default: begin
          fz_q <= fz_q;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      odata_q <= {4'b0, sat_q, tz_q, oz_q, fz_q, cnt_q, tot_q, orig_q, free_q};
    end
  end

  assign st_o.win_hit  = hit;
  assign st_o.div_done = div_done;
  assign st_o.out_busy = ov_q & ~out_ready_i;
  assign out_data_o    = odata_q;
  assign out_valid_o   = ov_q;

endmodule

>>> rtl/wrs_ctrl.sv
// controller: sequences item intake, window products, final products and divisions
`timescale 1ns / 1ps

module wrs_ctrl import wrs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  input  wrs_st_t  st_i,
  output wrs_cmd_t cmd_o
);

  wrs_state_e state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       last_q, last_d;
  div_sel_e   sel_q, sel_d;
  logic       accept;

  assign accept = (state_q == S_IDLE) & in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    sel_d   = sel_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          last_d = in_last_i;
          cnt_d  = '0;
          if (st_i.win_hit) begin
            state_d = S_WMUL;
          end else if (in_last_i) begin
            state_d = S_NMUL;
          end
        end
      end
      S_WMUL: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q[0]) begin
          state_d = S_WDRAIN;
        end
      end
      S_WDRAIN:  state_d = S_WCOMMIT;
      S_WCOMMIT: begin
        cnt_d   = '0;
        state_d = last_q ? S_NMUL : S_IDLE;
      end
      S_NMUL: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = S_NDRAIN;
        end
      end
      S_NDRAIN: state_d = S_NDIFF;
      S_NDIFF: begin
        cnt_d   = '0;
        state_d = S_DMUL;
      end
      S_DMUL: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = S_DDRAIN;
        end
      end
      S_DDRAIN: state_d = S_DDIFF;
      S_DDIFF: begin
        sel_d   = DIV_FREE;
        state_d = S_DIVGO;
      end
      S_DIVGO: state_d = S_DIVWAIT;
      S_DIVWAIT: begin
        if (st_i.div_done) begin
          unique case (sel_q)
            DIV_FREE: begin
              sel_d   = DIV_ORIGIN;
              state_d = S_DIVGO;
            end
            DIV_ORIGIN: begin
              sel_d   = DIV_TOTAL;
              state_d = S_DIVGO;
            end
            default: begin
              state_d = S_LOAD;
            end
          endcase
        end
      end
      S_LOAD: begin
        if (!st_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_pair = PAIR_N_SXY;
    cmd_o.div_sel  = sel_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.item     = accept;
      end
      S_WMUL: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_pair = cnt_q[0] ? PAIR_WA_WB : PAIR_WA_WA;
        cmd_o.mul_dst  = cnt_q[0];
      end
      S_WCOMMIT: cmd_o.win_commit = 1'b1;
      S_NMUL: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_pair = cnt_q[2] ? PAIR_SX_SY : PAIR_N_SXY;
        cmd_o.mul_part = cnt_q[1:0];
        cmd_o.mul_dst  = cnt_q[2];
      end
      S_NDIFF: cmd_o.num_latch = 1'b1;
      S_DMUL: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_pair = cnt_q[2] ? PAIR_SX_SX : PAIR_N_SXX;
        cmd_o.mul_part = cnt_q[1:0];
        cmd_o.mul_dst  = cnt_q[2];
      end
      S_DDIFF:   cmd_o.den_latch = 1'b1;
      S_DIVGO:   cmd_o.div_start = 1'b1;
      S_DIVWAIT: cmd_o.div_store = st_i.div_done;
      S_LOAD:    cmd_o.out_load  = ~st_i.out_busy;
      default: begin
        cmd_o.in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      sel_q   <= DIV_FREE;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      sel_q   <= sel_d;
    end
  end

endmodule

>>> rtl/wrs_checker.sv
// port-level checks of the windowed regression scaling block, bound to the top level
`timescale 1ns / 1ps

module wrs_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a last request keeps the block busy computing
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("request taken right after last");

  // a result appears only out of the busy phase
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without computation");

  // zero denominator gives zero ratio
  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tdata[128] || m_axis_tdata[31:0] == 32'd0) &&
                      (!m_axis_tdata[130] || m_axis_tdata[95:64] == 32'd0))
    else $error("nonzero ratio on zero denominator");

endmodule

bind windowed_regression_scaling_top wrs_checker u_wrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
